[sv/h2n_pkg.sv]
// Shared types and constants for the height-to-normal-map block.
// Used by h2n_normal_unit and height_to_normal_map; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package h2n_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = 11;
   localparam int ROW_W      = 16;

   // csr register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SCALE  = 2'd2;

   localparam logic [11:0] WIDTH_RST  = 12'd256;
   localparam logic [15:0] HEIGHT_RST = 16'd256;
   localparam logic [15:0] SCALE_RST  = 16'd256;

   // floor(m/255) = (m * RECIP_255) >> 31 for m below 2^24
   localparam logic [23:0] RECIP_255  = 24'h808081;
   localparam int          RECIP_SH   = 31;

   // integer square root and division sizes
   localparam int RAD_W   = 52;
   localparam int ROOT_W  = 26;
   localparam int QUOT_W  = 17;
   localparam int GRAD_W  = 25;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RUN
   } top_state_type;

   typedef enum logic [3:0] {
      U_IDLE,
      U_MUL,
      U_RECIP,
      U_GRAD,
      U_SQR,
      U_SUM,
      U_SQRT,
      U_DSET,
      U_DIV,
      U_ENC,
      U_DONE
   } unit_state_type;

   // one normal texel to compute
   typedef struct packed {
      logic [7:0]       h;
      logic [7:0]       right;
      logic [7:0]       below;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             eoi;
   } job_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef struct packed {
      logic [7:0]       nx;
      logic [7:0]       ny;
      logic [7:0]       nz;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             eoi;
   } result_type;

endpackage
`default_nettype wire

[sv/h2n_normal_unit.sv]
// Iterative normal computation: gradients, square root and three divisions.
// Depends on h2n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module h2n_normal_unit
   import h2n_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire job_type         job,
   input  wire logic [15:0]     scale,
   input  wire logic            take,
   output unit_status_type      status,
   output result_type           result
);

   unit_state_type state_ff, state_in;

   logic [7:0]          adx_ff, ady_ff;
   logic                negx_ff, negy_ff;
   logic [23:0]         mx_ff, my_ff;
   logic [47:0]         px_ff, py_ff;
   logic [GRAD_W-1:0]   gx_ff, gy_ff;
   logic [49:0]         sqx_ff, sqy_ff;
   logic [RAD_W-1:0]    rad_ff, root_ff, bit_ff;
   logic [ROOT_W-1:0]   len;
   logic [ROOT_W-1:0]   remx_ff, remy_ff, remz_ff;
   logic [QUOT_W-1:0]   numx_ff, numy_ff;
   logic [QUOT_W-1:0]   qx_ff, qy_ff, qz_ff;
   logic [4:0]          cnt_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                eoi_ff;
   result_type          res_ff;

   logic [RAD_W-1:0]    trial;
   logic [ROOT_W:0]     rsx, rsy, rsz;
   logic [23:0]         tx, ty, tz;

   assign len   = root_ff[ROOT_W-1:0];
   assign trial = root_ff + bit_ff;
   assign rsx   = {remx_ff, numx_ff[QUOT_W-1]};
   assign rsy   = {remy_ff, numy_ff[QUOT_W-1]};
   assign rsz   = {remz_ff, 1'b0};

   // byte encoding 128 + 127*n
   function automatic logic [23:0] enc(input logic neg, input logic [QUOT_W-1:0] q);
      logic [23:0] p;
      p = {q, 7'd0} - {7'd0, q};
      return neg ? (24'h800000 - p) : (24'h800000 + p);
   endfunction

   assign tx = enc(negx_ff, qx_ff);
   assign ty = enc(negy_ff, qy_ff);
   assign tz = enc(1'b0, qz_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE:  if (start) state_in = U_MUL;
         U_MUL:   state_in = U_RECIP;
         U_RECIP: state_in = U_GRAD;
         U_GRAD:  state_in = U_SQR;
         U_SQR:   state_in = U_SUM;
         U_SUM:   state_in = U_SQRT;
         U_SQRT:  if (bit_ff[0]) state_in = U_DSET;
         U_DSET:  state_in = U_DIV;
         U_DIV:   if (cnt_ff == 5'd0) state_in = U_ENC;
         U_ENC:   state_in = U_DONE;
         U_DONE:  if (take) state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      status.busy = (state_ff != U_IDLE);
      status.done = (state_ff == U_DONE);
      result      = res_ff;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               negx_ff <= job.h < job.right;
               negy_ff <= job.h < job.below;
               adx_ff  <= (job.h < job.right) ? job.right - job.h : job.h - job.right;
               ady_ff  <= (job.h < job.below) ? job.below - job.h : job.h - job.below;
               row_ff  <= job.row;
               col_ff  <= job.col;
               eoi_ff  <= job.eoi;
            end
         end
         U_MUL: begin
            mx_ff <= 24'(adx_ff) * 24'(scale);
            my_ff <= 24'(ady_ff) * 24'(scale);
         end
         U_RECIP: begin
            px_ff <= 48'(mx_ff) * 48'(RECIP_255);
            py_ff <= 48'(my_ff) * 48'(RECIP_255);
         end
         // m*256/255 = m + floor(m/255)
         U_GRAD: begin
            gx_ff <= {1'b0, mx_ff} + GRAD_W'(px_ff[47:RECIP_SH]);
            gy_ff <= {1'b0, my_ff} + GRAD_W'(py_ff[47:RECIP_SH]);
         end
         U_SQR: begin
            sqx_ff <= 50'(gx_ff) * 50'(gx_ff);
            sqy_ff <= 50'(gy_ff) * 50'(gy_ff);
         end
         U_SUM: begin
            rad_ff  <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff) + (RAD_W'(1) << 32);
            root_ff <= '0;
            bit_ff  <= RAD_W'(1) << 50;
         end
         // one result bit per cycle
         U_SQRT: begin
            if (rad_ff >= trial) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         // numerators: gx<<16, gy<<16 and 2^32, top part preloaded
         U_DSET: begin
            remx_ff <= ROOT_W'(gx_ff[GRAD_W-1:1]);
            remy_ff <= ROOT_W'(gy_ff[GRAD_W-1:1]);
            remz_ff <= ROOT_W'(1) << 15;
            numx_ff <= {gx_ff[0], 16'd0};
            numy_ff <= {gy_ff[0], 16'd0};
            qx_ff   <= '0;
            qy_ff   <= '0;
            qz_ff   <= '0;
            cnt_ff  <= 5'(QUOT_W - 1);
         end
         // restoring division, three lanes
         U_DIV: begin
            if (rsx >= {1'b0, len}) begin
               remx_ff <= ROOT_W'(rsx - {1'b0, len});
               qx_ff   <= {qx_ff[QUOT_W-2:0], 1'b1};
            end else begin
               remx_ff <= rsx[ROOT_W-1:0];
               qx_ff   <= {qx_ff[QUOT_W-2:0], 1'b0};
            end
            if (rsy >= {1'b0, len}) begin
               remy_ff <= ROOT_W'(rsy - {1'b0, len});
               qy_ff   <= {qy_ff[QUOT_W-2:0], 1'b1};
            end else begin
               remy_ff <= rsy[ROOT_W-1:0];
               qy_ff   <= {qy_ff[QUOT_W-2:0], 1'b0};
            end
            if (rsz >= {1'b0, len}) begin
               remz_ff <= ROOT_W'(rsz - {1'b0, len});
               qz_ff   <= {qz_ff[QUOT_W-2:0], 1'b1};
            end else begin
               remz_ff <= rsz[ROOT_W-1:0];
               qz_ff   <= {qz_ff[QUOT_W-2:0], 1'b0};
            end
            numx_ff <= {numx_ff[QUOT_W-2:0], 1'b0};
            numy_ff <= {numy_ff[QUOT_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff - 5'd1;
         end
         U_ENC: begin
            res_ff.nx  <= tx[23:16];
            res_ff.ny  <= ty[23:16];
            res_ff.nz  <= tz[23:16];
            res_ff.row <= row_ff;
            res_ff.col <= col_ff;
            res_ff.eoi <= eoi_ff;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/height_to_normal_map.sv]
// Top level of the height-to-normal-map block: stream ports, row memories,
// job sequencing and output register. Depends on h2n_pkg and h2n_normal_unit.
//
// Usage: height texels enter on the req_ channel in raster order, one beat
// per texel. Each normal leaves on the rsp_ channel once the texel below it
// has arrived; on the last row an input beat yields up to three normals, and
// rsp_tlast marks the final texel of the image. Image width, height and
// bump scale are written over the csr_ port; the user must do so only while
// the block is idle, which the block itself does not enforce. Each input
// beat passes the accept, memory read and dispatch states; its normals are
// computed in turn by the shared normal unit (26 square root steps and 17
// division steps), and no new beat is accepted until the last has left it.
// Reset clears counters and row-start registers; the row memories need no
// clearing pass. When the receiver stalls, one finished normal waits in the
// output register and the unit holds the next one until that beat leaves.
`timescale 1ns / 1ps
`default_nettype none
module height_to_normal_map
   import h2n_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // height_texel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // normal_x, normal_y, normal_z, alpha_byte,
                                         // out_row, out_col, zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   top_state_type state_ff, state_in;

   logic [11:0]       width_ff;
   logic [15:0]       height_ff, scale_ff;
   logic [COL_W-1:0]  col_ff, wm1, col_cur;
   logic [ROW_W-1:0]  row_ff, hm1, row_cur;
   logic              accept;

   logic [7:0]        prev_ff, rs_ff, prior_ff;
   logic [7:0]        v_ff, prior_use_ff, rs_use_ff, prev_use_ff;
   logic [COL_W-1:0]  c_ff;
   logic [ROW_W-1:0]  r_ff;
   logic              lastc_ff, lastr_ff;
   logic [2:0]        pend_ff, pend_in;

   logic [7:0]        line_mem  [MAX_WIDTH];
   logic [7:0]        first_mem [MAX_WIDTH];
   logic [7:0]        ln_a_ff, ln_b_ff, fr_a_ff, fr_b_ff;

   job_type           job;
   logic              start, take;
   unit_status_type   status;
   result_type        result;
   result_type        out_ff;
   logic              out_valid_ff;

   assign accept = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         scale_ff  <= SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[11:0];
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_SCALE:  scale_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // effective last column and row, clamped position
   always_comb begin
      if (width_ff == 12'd0) begin
         wm1 = '0;
      end else if (width_ff > 12'(MAX_WIDTH)) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(width_ff - 12'd1);
      end
      hm1     = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;
      col_cur = (col_ff >= wm1) ? wm1 : col_ff;
      row_cur = (row_ff >= hm1) ? hm1 : row_ff;
   end

   // position counters and row-start texels
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prev_ff  <= '0;
         rs_ff    <= '0;
         prior_ff <= '0;
      end else if (accept) begin
         if (col_cur == wm1) begin
            col_ff <= '0;
            row_ff <= (row_cur == hm1) ? '0 : row_cur + 16'd1;
         end else begin
            col_ff <= col_cur + 11'd1;
            row_ff <= row_cur;
         end
         if (col_cur == '0) begin
            prior_ff <= rs_ff;
            rs_ff    <= req_tdata;
         end
         prev_ff <= req_tdata;
      end
   end

   // per-beat operands
   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff         <= req_tdata;
         c_ff         <= col_cur;
         r_ff         <= row_cur;
         lastc_ff     <= (col_cur == wm1);
         lastr_ff     <= (row_cur == hm1);
         prior_use_ff <= (col_cur == '0) ? rs_ff : prior_ff;
         rs_use_ff    <= (col_cur == '0) ? req_tdata : rs_ff;
         prev_use_ff  <= prev_ff;
      end
   end

   // row memories: read old contents, write the new texel (the first-row memory only on row 0)
   always_ff @(posedge clock) begin
      if (accept) begin
         ln_a_ff           <= line_mem[col_cur];
         ln_b_ff           <= line_mem[col_cur + 11'd1];
         line_mem[col_cur] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_a_ff <= first_mem[col_cur - 11'd1];
         fr_b_ff <= first_mem[col_cur];
         if (row_cur == '0) begin
            first_mem[col_cur] <= req_tdata;
         end
      end
   end

   // job selection: texel above, left neighbour, then own texel
   always_comb begin
      if (pend_ff[0]) begin
         job.h     = ln_a_ff;
         job.right = lastc_ff ? prior_use_ff : ln_b_ff;
         job.below = v_ff;
         job.row   = r_ff - 16'd1;
         job.col   = c_ff;
         job.eoi   = 1'b0;
      end else if (pend_ff[1]) begin
         job.h     = prev_use_ff;
         job.right = v_ff;
         job.below = fr_a_ff;
         job.row   = r_ff;
         job.col   = c_ff - 11'd1;
         job.eoi   = 1'b0;
      end else begin
         job.h     = v_ff;
         job.right = rs_use_ff;
         job.below = (r_ff == '0) ? v_ff : fr_b_ff;
         job.row   = r_ff;
         job.col   = c_ff;
         job.eoi   = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_RUN;
         ST_RUN:   if (pend_ff == 3'd0 && !status.busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      start      = (state_ff == ST_RUN) && !status.busy && (pend_ff != 3'd0);
      take       = status.done && (!out_valid_ff || rsp_tready);
      pend_in    = pend_ff;
      if (state_ff == ST_FETCH) begin
         pend_in = {lastr_ff && lastc_ff, lastr_ff && (c_ff != '0), r_ff != '0};
      end else if (start) begin
         if (pend_ff[0]) begin
            pend_in[0] = 1'b0;
         end else if (pend_ff[1]) begin
            pend_in[1] = 1'b0;
         end else begin
            pend_in[2] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   h2n_normal_unit u_normal (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .job    (job),
      .scale  (scale_ff),
      .take   (take),
      .status (status),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.col, out_ff.row, 8'hFF,
                        out_ff.nz, out_ff.ny, out_ff.nx};
   assign rsp_tlast  = out_ff.eoi;

endmodule
`default_nettype wire

[dv/height_to_normal_map_tb.sv]
// Self-checking testbench for height_to_normal_map: streams height images,
// predicts every normal beat and compares against the rsp_ channel.
// Depends on h2n_pkg and the height_to_normal_map RTL.
`timescale 1ns / 1ps
module height_to_normal_map_tb
   import h2n_pkg::*;
();

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // height_texel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // normal_x, normal_y, normal_z, alpha_byte, out_row, out_col, pad
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   height_to_normal_map uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct {
      logic [7:0]  nx;
      logic [7:0]  ny;
      logic [7:0]  nz;
      logic [15:0] row;
      logic [10:0] col;
      logic        eoi;
   } normal_beat_type;

   // mirror of the block: row memories, counters and the normal arithmetic
   class normal_scoreboard;
      logic [11:0]  cfg_width;
      logic [15:0]  cfg_height;
      logic [15:0]  cfg_scale;
      logic [7:0]   line_mem[MAX_WIDTH];
      logic [7:0]   top_row_mem[MAX_WIDTH];
      logic [7:0]   last_texel;
      logic [7:0]   row_first;
      logic [7:0]   prev_row_first;
      int unsigned  col_cnt;
      int unsigned  row_cnt;
      normal_beat_type expected_normals[$];
      int           errors;

      function new();
         cfg_width = WIDTH_RST;
         cfg_height = HEIGHT_RST;
         cfg_scale = SCALE_RST;
         last_texel = 0;
         row_first = 0;
         prev_row_first = 0;
         col_cnt = 0;
         row_cnt = 0;
         errors = 0;
         foreach (line_mem[i]) begin
            line_mem[i] = 0;
            top_row_mem[i] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == CSR_WIDTH) cfg_width = val[11:0];
         else if (idx == CSR_HEIGHT) cfg_height = val;
         else if (idx == CSR_SCALE) cfg_scale = val;
      endfunction

      function longint slope(int h, int nb);
         longint mag;
         mag = (h >= nb) ? h - nb : nb - h;
         mag = (mag * cfg_scale * 256) / 255;
         return (h < nb) ? -mag : mag;
      endfunction

      function longint root(longint v);
         longint res;
         longint b;
         res = 0;
         b = longint'(1) << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [7:0] to_byte(longint n);
         longint t;
         t = 128 * 65536 + 127 * n;
         if (t < 0) t = 0;
         return t[23:16];
      endfunction

      function longint unit_div(longint x, longint len);
         longint q;
         q = ((x < 0 ? -x : x) << 16) / len;
         return (x < 0) ? -q : q;
      endfunction

      function void add_normal(int h, int right, int below, int row, int col, bit eoi);
         longint gx, gy, len;
         normal_beat_type nb;
         gx = slope(h, right);
         gy = slope(h, below);
         len = root(gx * gx + gy * gy + (longint'(1) << 32));
         nb.nx = to_byte(unit_div(gx, len));
         nb.ny = to_byte(unit_div(gy, len));
         nb.nz = to_byte((longint'(1) << 32) / len);
         nb.row = row[15:0];
         nb.col = col[10:0];
         nb.eoi = eoi;
         expected_normals.push_back(nb);
      endfunction

      // accepted texel: update the mirror and queue the normals it releases
      function void note_texel(logic [7:0] v);
         int unsigned w, hgt, c, r;
         bit last_c, last_r;
         w = (cfg_width == 0) ? 1 : cfg_width;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         hgt = (cfg_height == 0) ? 1 : cfg_height;
         c = (col_cnt >= w - 1) ? w - 1 : col_cnt;
         r = (row_cnt >= hgt - 1) ? hgt - 1 : row_cnt;
         last_c = (c == w - 1);
         last_r = (r == hgt - 1);
         if (c == 0) begin
            prev_row_first = row_first;
            row_first = v;
         end
         if (r == 0) top_row_mem[c] = v;
         if (r > 0)
            add_normal(line_mem[c], last_c ? prev_row_first : line_mem[(c + 1) % MAX_WIDTH],
                       v, r - 1, c, 0);
         line_mem[c] = v;
         if (last_r) begin
            if (c > 0) add_normal(last_texel, v, top_row_mem[c - 1], r, c - 1, 0);
            if (last_c) add_normal(v, row_first, top_row_mem[c], r, c, 1);
         end
         last_texel = v;
         if (last_c) begin
            col_cnt = 0;
            row_cnt = last_r ? 0 : r + 1;
         end else begin
            col_cnt = c + 1;
            row_cnt = r;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_normal(logic [63:0] d, logic last);
         normal_beat_type e;
         if (expected_normals.size() == 0) begin
            report($sformatf("unexpected normal beat %h", d));
            return;
         end
         e = expected_normals.pop_front();
         if (d[7:0] !== e.nx || d[15:8] !== e.ny || d[23:16] !== e.nz ||
             d[31:24] !== 8'd255 || d[47:32] !== e.row || d[58:48] !== e.col ||
             last !== e.eoi)
            report($sformatf("row %0d col %0d: got %h/%b want n=%h,%h,%h r%0d c%0d eoi %b",
                             e.row, e.col, d, last, e.nx, e.ny, e.nz, e.row, e.col, e.eoi));
      endtask
   endclass

   normal_scoreboard sb;
   bit  quiet;
   bit  long_hold;
   int  cycles;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stall bursts plus one long hold
   initial begin : receiver
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_normal(rsp_tdata, rsp_tlast);
         if (long_hold) begin
            stall = 800;
            long_hold = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 10);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.expected_normals.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_texel(logic [7:0] v);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      sb.note_texel(v);
   endtask

   function automatic logic [7:0] pick_texel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_image(int w, int h, int scale);
      write_csr(CSR_WIDTH, 16'(w));
      write_csr(CSR_HEIGHT, 16'(h));
      write_csr(CSR_SCALE, 16'(scale));
      repeat (((w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w)) * ((h == 0) ? 1 : h))
         send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();
   endtask

   initial begin : stimulus
      int sent;
      int w, h;
      sb = new();
      quiet = 0;
      long_hold = 0;
      cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = 16'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero sizes act as one texel, zero gain gives flat normals
      run_image(0, 0, 0);
      run_image(1, 1, 16'hFFFF);
      // 2x2 with opposite extremes so both slopes saturate in each sign
      write_csr(CSR_WIDTH, 16'd2);
      write_csr(CSR_HEIGHT, 16'd2);
      send_texel(8'd0);
      send_texel(8'd255);
      send_texel(8'd255);
      send_texel(8'd0);
      req_tvalid <= 1'b0;
      drain();
      // tallest height, then shrunk mid-image so the count clamps to the last row
      write_csr(CSR_WIDTH, 16'd3);
      write_csr(CSR_HEIGHT, 16'hFFFF);
      write_csr(CSR_SCALE, 16'd256);
      repeat (6) send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();
      write_csr(CSR_HEIGHT, 16'd3);
      repeat (3) send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();
      // width above the maximum acts as the maximum, then shrunk mid-row
      write_csr(CSR_WIDTH, 16'h0FFF);
      write_csr(CSR_HEIGHT, 16'd2);
      write_csr(CSR_SCALE, 16'd1000);
      repeat (3) send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();
      write_csr(CSR_WIDTH, 16'd3);
      repeat (4) send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();

      // receiver holds off long while the sender keeps offering
      write_csr(CSR_WIDTH, 16'd6);
      write_csr(CSR_HEIGHT, 16'd4);
      write_csr(CSR_SCALE, 16'($urandom_range(0, 65535)));
      long_hold = 1;
      repeat (24) send_texel(pick_texel());
      req_tvalid <= 1'b0;
      drain();

      // random images, no idling in the last stretch
      sent = 0;
      while (sent < 75) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         if (sent > 50) quiet = 1;
         case ($urandom_range(0, 5))
            0: run_image(w, h, 0);
            1: run_image(w, h, 16'hFFFF);
            default: run_image(w, h, $urandom_range(0, 4096));
         endcase
         sent += w * h;
      end

      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/h2n_pkg.sv
sv/h2n_normal_unit.sv
sv/height_to_normal_map.sv
dv/height_to_normal_map_tb.sv
